// File: sv/ixe_pkg.sv
`timescale 1ns / 1ps

package ixe_pkg;

   // Fixed field and state widths.
   localparam int VAL_W       = 48;
   localparam int FRAC_W      = 32;
   localparam int FDIG_W      = 4;
   localparam int CH_W        = 8;
   localparam int DIGIT_W     = 4;
   localparam int POW10_W     = 30;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int MUL_CHUNK   = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = 2;

   // Character codes.
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

   // Saturation limits of the 48-bit signed format.
   localparam logic [VAL_W-1:0] VAL_MAX     = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN     = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [VAL_W:0]   MAG_CAP     = {1'b1, {VAL_W{1'b0}}};
   localparam logic [VAL_W:0]   MAG_NEG_LIM = {2'b01, {(VAL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      TK_DIGIT,
      TK_POINT,
      TK_ADD,
      TK_SUB,
      TK_MUL,
      TK_DIV,
      TK_BAD
   } token_kind_type;

   typedef struct packed {
      token_kind_type     kind;
      logic [DIGIT_W-1:0] digit;
      logic               last;
      logic               expr_ok;
   } token_type;

   typedef enum logic [1:0] {
      MOP_NONE,
      MOP_MUL,
      MOP_DIV
   } mul_op_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_CONV,
      BK_CONV_WAIT,
      BK_APPLY,
      BK_MUL,
      BK_MUL_DONE,
      BK_DIV_START,
      BK_DIV_WAIT,
      BK_OPERATOR,
      BK_FOLD,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             err;
   } sat_type;

   function automatic logic [POW10_W-1:0] pow10(input logic [FDIG_W-1:0] d);
      logic [POW10_W-1:0] p;
      case (d)
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

   // Magnitude of a two's complement value; the most negative value maps to 2^47.
   function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
      return v[VAL_W-1] ? VAL_W'(~v + VAL_W'(1)) : v;
   endfunction

   // Gives a capped magnitude its sign and saturates to the signed range.
   function automatic sat_type apply_sign(input logic [VAL_W:0] mag, input logic neg);
      sat_type r;
      r.err = 1'b0;
      if (neg) begin
         if (mag > MAG_NEG_LIM) begin
            r.value = VAL_MIN;
            r.err   = 1'b1;
         end else begin
            r.value = VAL_W'(~mag + (VAL_W+1)'(1));
         end
      end else begin
         if (mag >= MAG_NEG_LIM) begin
            r.value = VAL_MAX;
            r.err   = 1'b1;
         end else begin
            r.value = mag[VAL_W-1:0];
         end
      end
      return r;
   endfunction

   // Saturates a 49-bit exact sum of two 48-bit signed values.
   function automatic sat_type sat_sum(input logic [VAL_W:0] s);
      sat_type r;
      if (s[VAL_W] != s[VAL_W-1]) begin
         r.value = s[VAL_W] ? VAL_MIN : VAL_MAX;
         r.err   = 1'b1;
      end else begin
         r.value = s[VAL_W-1:0];
         r.err   = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: sv/ixe_front.sv
`timescale 1ns / 1ps

// Classifies each character into a token and keeps the per-expression checks.
module ixe_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ixe_pkg::CH_W-1:0]    req_ch,
   input  logic                        req_last,
   input  logic                        q_full,
   output logic                        q_push,
   output ixe_pkg::token_type          q_token
);

   logic [1:0] num_cnt_ff, num_cnt_in;
   logic       seen_op_ff, seen_op_in;
   logic       bad_ff, bad_in;
   logic       is_digit, is_point, is_op, is_bad, is_num;
   logic [1:0] cnt_eff;
   logic       accept;
   ixe_pkg::token_kind_type kind;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      is_digit = (req_ch >= ixe_pkg::CH_ZERO) && (req_ch <= ixe_pkg::CH_NINE);
      is_point = (req_ch == ixe_pkg::CH_POINT);
      kind     = ixe_pkg::TK_BAD;
      if (is_digit) begin
         kind = ixe_pkg::TK_DIGIT;
      end else if (is_point) begin
         kind = ixe_pkg::TK_POINT;
      end else if (req_ch == ixe_pkg::CH_PLUS) begin
         kind = ixe_pkg::TK_ADD;
      end else if (req_ch == ixe_pkg::CH_MINUS) begin
         kind = ixe_pkg::TK_SUB;
      end else if (req_ch == ixe_pkg::CH_STAR) begin
         kind = ixe_pkg::TK_MUL;
      end else if (req_ch == ixe_pkg::CH_SLASH) begin
         kind = ixe_pkg::TK_DIV;
      end
      is_num = is_digit || is_point;
      is_op  = (kind == ixe_pkg::TK_ADD) || (kind == ixe_pkg::TK_SUB) ||
               (kind == ixe_pkg::TK_MUL) || (kind == ixe_pkg::TK_DIV);
      is_bad = (kind == ixe_pkg::TK_BAD);
      cnt_eff = (is_num && (num_cnt_ff != 2'd2)) ? num_cnt_ff + 2'd1 : num_cnt_ff;

      q_token.kind    = kind;
      q_token.digit   = ixe_pkg::DIGIT_W'(req_ch - ixe_pkg::CH_ZERO);
      q_token.last    = req_last;
      q_token.expr_ok = !(bad_ff || is_bad) && (cnt_eff == 2'd2) && (seen_op_ff || is_op);

      num_cnt_in = num_cnt_ff;
      seen_op_in = seen_op_ff;
      bad_in     = bad_ff;
      if (accept) begin
         if (req_last) begin
            num_cnt_in = 2'd0;
            seen_op_in = 1'b0;
            bad_in     = 1'b0;
         end else begin
            num_cnt_in = cnt_eff;
            seen_op_in = seen_op_ff || is_op;
            bad_in     = bad_ff || is_bad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cnt_ff <= 2'd0;
         seen_op_ff <= 1'b0;
         bad_ff     <= 1'b0;
      end else begin
         num_cnt_ff <= num_cnt_in;
         seen_op_ff <= seen_op_in;
         bad_ff     <= bad_in;
      end
   end

endmodule

// File: sv/ixe_queue.sv
`timescale 1ns / 1ps

// Short token queue between the classifier and the evaluation engine.
module ixe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ixe_pkg::token_type push_token,
   input  logic               pop,
   output ixe_pkg::token_type head_token,
   output logic               full,
   output logic               empty
);

   ixe_pkg::token_type          slots_ff [ixe_pkg::QUEUE_DEPTH];
   logic [ixe_pkg::QIDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ixe_pkg::QIDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ixe_pkg::QIDX_W:0]    count_ff, count_in;
   logic                        do_push, do_pop;

   assign full       = (count_ff == (ixe_pkg::QIDX_W+1)'(ixe_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_token = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/ixe_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module ixe_div #(
   parameter int NUM_W = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [NUM_W-1:0]          numer,
   input  logic [ixe_pkg::VAL_W-1:0] denom,
   output logic                      done,
   output logic [NUM_W-1:0]          quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [NUM_W-1:0]          work_ff, work_in;
   logic [ixe_pkg::VAL_W-1:0] rem_ff, rem_in;
   logic [ixe_pkg::VAL_W-1:0] den_ff, den_in;
   logic [ixe_pkg::VAL_W:0]   rem_sh;
   logic                      ge;

   assign done = done_ff;
   assign quo  = work_ff;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         work_in = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         work_in = {work_ff[NUM_W-2:0], ge};
         rem_in  = ge ? ixe_pkg::VAL_W'(rem_sh - {1'b0, den_ff}) : rem_sh[ixe_pkg::VAL_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: sv/ixe_back.sv
`timescale 1ns / 1ps

// Evaluation engine: builds numbers, folds terms and sums, drives the result register.
module ixe_back #(
   parameter int FRAC_BITS           = 16,
   parameter int MAX_FRACTION_DIGITS = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  ixe_pkg::token_type               q_token,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ixe_pkg::VAL_W-1:0] rsp_value,
   output logic                             rsp_valid_res,
   output logic                             rsp_arith_error
);

   localparam int VW    = ixe_pkg::VAL_W;
   localparam int NUM_W = VW + FRAC_BITS;
   localparam logic [VW-1:0] INT_LIMIT = VW'(1) << (VW - 1 - FRAC_BITS);

   ixe_pkg::back_state_type state_ff, state_in;
   ixe_pkg::token_type      tok_ff, tok_in;
   ixe_pkg::mul_op_type     mul_op_ff, mul_op_in;

   logic [VW-1:0]                  sum_ff, sum_in;
   logic [VW-1:0]                  term_ff, term_in;
   logic [VW-1:0]                  ip_ff, ip_in;
   logic [ixe_pkg::FRAC_W-1:0]     frac_ff, frac_in;
   logic [ixe_pkg::FDIG_W-1:0]     fdig_ff, fdig_in;
   logic                           in_frac_ff, in_frac_in;
   logic                           add_op_ff, add_op_in;
   logic                           err_ff, err_in;
   logic                           final_ff, final_in;
   logic [VW-1:0]                  num_ff, num_in;
   logic [VW-1:0]                  mag_a_ff, mag_a_in;
   logic [VW-1:0]                  mag_b_ff, mag_b_in;
   logic                           neg_ff, neg_in;
   logic [ixe_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic [VW+ixe_pkg::MUL_CHUNK-1:0] pp_ff, pp_in;
   logic [1:0]                     mcnt_ff, mcnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                  rsp_value_ff, rsp_value_in;
   logic                           rsp_ok_ff, rsp_ok_in;
   logic                           rsp_err_ff, rsp_err_in;

   logic                           div_start, div_done;
   logic [NUM_W-1:0]               div_numer, div_quo;
   logic [VW-1:0]                  div_denom;
   logic                           emit_load;
   logic                           head_is_op;

   logic [ixe_pkg::POW10_W-1:0]    p10;
   logic [VW+3:0]                  ip_x10;
   logic [VW:0]                    conv_sum;
   logic [ixe_pkg::MUL_CHUNK-1:0]  b_chunk;
   logic [ixe_pkg::PROD_W-1:0]     pp_shifted;
   logic [ixe_pkg::PROD_W-FRAC_BITS-1:0] prod_sh;
   logic [VW:0]                    cap_mag;
   logic [VW:0]                    fold_raw;
   ixe_pkg::sat_type               sat_r;

   ixe_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_valid_res   = rsp_ok_ff;
   assign rsp_arith_error = rsp_err_ff;

   assign head_is_op = (q_token.kind == ixe_pkg::TK_ADD) || (q_token.kind == ixe_pkg::TK_SUB) ||
                       (q_token.kind == ixe_pkg::TK_MUL) || (q_token.kind == ixe_pkg::TK_DIV);
   assign emit_load  = (state_ff == ixe_pkg::BK_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ixe_pkg::BK_IDLE: begin
            if (!q_empty && (head_is_op || q_token.last)) begin
               state_in = ixe_pkg::BK_CONV;
            end
         end
         ixe_pkg::BK_CONV: begin
            if ((ip_ff < INT_LIMIT) && (fdig_ff != '0)) begin
               state_in = ixe_pkg::BK_CONV_WAIT;
            end else begin
               state_in = ixe_pkg::BK_APPLY;
            end
         end
         ixe_pkg::BK_CONV_WAIT: begin
            if (div_done) begin
               state_in = ixe_pkg::BK_APPLY;
            end
         end
         ixe_pkg::BK_APPLY: begin
            case (mul_op_ff)
               ixe_pkg::MOP_MUL: state_in = ixe_pkg::BK_MUL;
               ixe_pkg::MOP_DIV: begin
                  if (num_ff == '0) begin
                     state_in = final_ff ? ixe_pkg::BK_FOLD : ixe_pkg::BK_OPERATOR;
                  end else begin
                     state_in = ixe_pkg::BK_DIV_START;
                  end
               end
               default: state_in = final_ff ? ixe_pkg::BK_FOLD : ixe_pkg::BK_OPERATOR;
            endcase
         end
         ixe_pkg::BK_MUL: begin
            if (mcnt_ff == 2'd3) begin
               state_in = ixe_pkg::BK_MUL_DONE;
            end
         end
         ixe_pkg::BK_MUL_DONE: begin
            state_in = final_ff ? ixe_pkg::BK_FOLD : ixe_pkg::BK_OPERATOR;
         end
         ixe_pkg::BK_DIV_START: begin
            state_in = ixe_pkg::BK_DIV_WAIT;
         end
         ixe_pkg::BK_DIV_WAIT: begin
            if (div_done) begin
               state_in = final_ff ? ixe_pkg::BK_FOLD : ixe_pkg::BK_OPERATOR;
            end
         end
         ixe_pkg::BK_OPERATOR: begin
            state_in = tok_ff.last ? ixe_pkg::BK_CONV : ixe_pkg::BK_IDLE;
         end
         ixe_pkg::BK_FOLD: begin
            state_in = ixe_pkg::BK_EMIT;
         end
         ixe_pkg::BK_EMIT: begin
            if (emit_load) begin
               state_in = ixe_pkg::BK_IDLE;
            end
         end
         default: state_in = ixe_pkg::BK_IDLE;
      endcase
   end

   // Handshake and divider controls.
   always_comb begin
      p10       = ixe_pkg::pow10(fdig_ff);
      q_pop     = (state_ff == ixe_pkg::BK_IDLE) && !q_empty;
      div_start = 1'b0;
      div_numer = {mag_a_ff, FRAC_BITS'(0)};
      div_denom = mag_b_ff;
      case (state_ff)
         ixe_pkg::BK_CONV: begin
            div_start = (ip_ff < INT_LIMIT) && (fdig_ff != '0);
            div_numer = (NUM_W'(frac_ff) << FRAC_BITS) + NUM_W'(p10 >> 1);
            div_denom = VW'(p10);
         end
         ixe_pkg::BK_DIV_START: begin
            div_start = 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      tok_in     = tok_ff;
      mul_op_in  = mul_op_ff;
      sum_in     = sum_ff;
      term_in    = term_ff;
      ip_in      = ip_ff;
      frac_in    = frac_ff;
      fdig_in    = fdig_ff;
      in_frac_in = in_frac_ff;
      add_op_in  = add_op_ff;
      err_in     = err_ff;
      final_in   = final_ff;
      num_in     = num_ff;
      mag_a_in   = mag_a_ff;
      mag_b_in   = mag_b_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      pp_in      = pp_ff;
      mcnt_in    = mcnt_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_err_in   = rsp_err_ff;

      ip_x10   = ({4'b0, ip_ff} << 3) + ({4'b0, ip_ff} << 1) + (VW+4)'(q_token.digit);
      conv_sum = ((VW+1)'(ip_ff) << FRAC_BITS) + (VW+1)'(div_quo);
      fold_raw = add_op_ff ? {sum_ff[VW-1], sum_ff} - {term_ff[VW-1], term_ff}
                           : {sum_ff[VW-1], sum_ff} + {term_ff[VW-1], term_ff};
      prod_sh  = acc_ff[ixe_pkg::PROD_W-1:FRAC_BITS];
      cap_mag  = '0;
      sat_r    = '0;

      case (mcnt_ff)
         2'd0:    b_chunk = mag_b_ff[ixe_pkg::MUL_CHUNK-1:0];
         2'd1:    b_chunk = mag_b_ff[2*ixe_pkg::MUL_CHUNK-1:ixe_pkg::MUL_CHUNK];
         2'd2:    b_chunk = mag_b_ff[3*ixe_pkg::MUL_CHUNK-1:2*ixe_pkg::MUL_CHUNK];
         default: b_chunk = '0;
      endcase
      case (mcnt_ff)
         2'd2:    pp_shifted = ixe_pkg::PROD_W'(pp_ff) << ixe_pkg::MUL_CHUNK;
         2'd3:    pp_shifted = ixe_pkg::PROD_W'(pp_ff) << (2 * ixe_pkg::MUL_CHUNK);
         default: pp_shifted = ixe_pkg::PROD_W'(pp_ff);
      endcase

      case (state_ff)
         ixe_pkg::BK_IDLE: begin
            if (!q_empty) begin
               tok_in   = q_token;
               final_in = !head_is_op;
               case (q_token.kind)
                  ixe_pkg::TK_DIGIT: begin
                     if (in_frac_ff) begin
                        if (fdig_ff < ixe_pkg::FDIG_W'(MAX_FRACTION_DIGITS)) begin
                           frac_in = ixe_pkg::FRAC_W'((frac_ff << 3) + (frac_ff << 1) +
                                                      ixe_pkg::FRAC_W'(q_token.digit));
                           fdig_in = fdig_ff + 1'b1;
                        end
                     end else begin
                        ip_in = (ip_x10 > (VW+4)'(INT_LIMIT)) ? INT_LIMIT : VW'(ip_x10);
                     end
                  end
                  ixe_pkg::TK_POINT: begin
                     in_frac_in = 1'b1;
                  end
                  default: begin
                     in_frac_in = in_frac_ff;
                  end
               endcase
            end
         end
         ixe_pkg::BK_CONV: begin
            if (ip_ff >= INT_LIMIT) begin
               num_in = ixe_pkg::VAL_MAX;
               err_in = 1'b1;
            end else if (fdig_ff == '0) begin
               num_in = VW'(ip_ff << FRAC_BITS);
            end
         end
         ixe_pkg::BK_CONV_WAIT: begin
            if (div_done) begin
               if (conv_sum >= ixe_pkg::MAG_NEG_LIM) begin
                  num_in = ixe_pkg::VAL_MAX;
                  err_in = 1'b1;
               end else begin
                  num_in = conv_sum[VW-1:0];
               end
            end
         end
         ixe_pkg::BK_APPLY: begin
            // The number is consumed here, so the builder starts over.
            ip_in      = '0;
            frac_in    = '0;
            fdig_in    = '0;
            in_frac_in = 1'b0;
            mul_op_in  = ixe_pkg::MOP_NONE;
            mag_a_in   = ixe_pkg::magnitude(term_ff);
            mag_b_in   = ixe_pkg::magnitude(num_ff);
            neg_in     = term_ff[VW-1] ^ num_ff[VW-1];
            acc_in     = '0;
            mcnt_in    = 2'd0;
            case (mul_op_ff)
               ixe_pkg::MOP_MUL: begin
                  term_in = term_ff;
               end
               ixe_pkg::MOP_DIV: begin
                  if (num_ff == '0) begin
                     // Division by zero saturates toward the dividend's sign.
                     err_in = 1'b1;
                     if (term_ff[VW-1]) begin
                        term_in = ixe_pkg::VAL_MIN;
                     end else if (term_ff != '0) begin
                        term_in = ixe_pkg::VAL_MAX;
                     end
                  end
               end
               default: begin
                  term_in = num_ff;
               end
            endcase
         end
         ixe_pkg::BK_MUL: begin
            pp_in   = mag_a_ff * b_chunk;
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff != 2'd0) begin
               acc_in = acc_ff + pp_shifted;
            end
         end
         ixe_pkg::BK_MUL_DONE: begin
            cap_mag = (prod_sh > (ixe_pkg::PROD_W-FRAC_BITS)'(ixe_pkg::MAG_CAP)) ?
                      ixe_pkg::MAG_CAP : (VW+1)'(prod_sh);
            sat_r   = ixe_pkg::apply_sign(cap_mag, neg_ff);
            term_in = sat_r.value;
            err_in  = err_ff || sat_r.err;
         end
         ixe_pkg::BK_DIV_WAIT: begin
            if (div_done) begin
               cap_mag = (div_quo > NUM_W'(ixe_pkg::MAG_CAP)) ?
                         ixe_pkg::MAG_CAP : (VW+1)'(div_quo);
               sat_r   = ixe_pkg::apply_sign(cap_mag, neg_ff);
               term_in = sat_r.value;
               err_in  = err_ff || sat_r.err;
            end
         end
         ixe_pkg::BK_OPERATOR: begin
            final_in = 1'b1;
            case (tok_ff.kind)
               ixe_pkg::TK_ADD, ixe_pkg::TK_SUB: begin
                  sat_r     = ixe_pkg::sat_sum(fold_raw);
                  sum_in    = sat_r.value;
                  err_in    = err_ff || sat_r.err;
                  term_in   = '0;
                  add_op_in = (tok_ff.kind == ixe_pkg::TK_SUB);
               end
               ixe_pkg::TK_MUL: mul_op_in = ixe_pkg::MOP_MUL;
               ixe_pkg::TK_DIV: mul_op_in = ixe_pkg::MOP_DIV;
               default:         mul_op_in = mul_op_ff;
            endcase
         end
         ixe_pkg::BK_FOLD: begin
            sat_r   = ixe_pkg::sat_sum(fold_raw);
            sum_in  = sat_r.value;
            err_in  = err_ff || sat_r.err;
            term_in = '0;
         end
         ixe_pkg::BK_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = tok_ff.expr_ok;
               rsp_value_in = tok_ff.expr_ok ? sum_ff : '0;
               rsp_err_in   = tok_ff.expr_ok && err_ff;
               sum_in       = '0;
               term_in      = '0;
               add_op_in    = 1'b0;
               mul_op_in    = ixe_pkg::MOP_NONE;
               err_in       = 1'b0;
            end
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tok_ff       <= tok_in;
      num_ff       <= num_in;
      mag_a_ff     <= mag_a_in;
      mag_b_ff     <= mag_b_in;
      neg_ff       <= neg_in;
      acc_ff       <= acc_in;
      pp_ff        <= pp_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ixe_pkg::BK_IDLE;
         mul_op_ff    <= ixe_pkg::MOP_NONE;
         sum_ff       <= '0;
         term_ff      <= '0;
         ip_ff        <= '0;
         frac_ff      <= '0;
         fdig_ff      <= '0;
         in_frac_ff   <= 1'b0;
         add_op_ff    <= 1'b0;
         err_ff       <= 1'b0;
         final_ff     <= 1'b0;
         mcnt_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_op_ff    <= mul_op_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         ip_ff        <= ip_in;
         frac_ff      <= frac_in;
         fdig_ff      <= fdig_in;
         in_frac_ff   <= in_frac_in;
         add_op_ff    <= add_op_in;
         err_ff       <= err_in;
         final_ff     <= final_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/infix_expression_evaluator.sv
`timescale 1ns / 1ps

// Four-function infix calculator that takes an expression one ASCII character per
// transaction on the req_ channel and returns one result transaction on the rsp_
// channel after the character flagged by req_last. Multiply and divide bind tighter
// than add and subtract, a missing operand counts as zero, and the result is a signed
// 48-bit fixed-point value with FRAC_BITS fraction bits; every step saturates and
// flags rsp_arith_error, which also reports division by zero. rsp_valid_res is low
// (and the value and error flag are zero) when the expression held a character other
// than a digit, point or operator, fewer than two digit or point characters, or no
// operator. A classifier accepts one character per cycle into a four-entry token
// queue while it is not full, so bursts are absorbed while the evaluation engine
// works. The engine takes a digit or point as it pops it; an operator first
// finishes the pending number, which for a number with a fraction costs one pass
// of the bit-serial divider over its 48 + FRAC_BITS numerator bits and a hand-over
// of the quotient, then a multiply (48x16 partial products, one per 16-bit chunk
// of the multiplier) or a divide (another divider pass), and for + or - a fold.
// Number conversion and division share the one divider; the final character adds
// one more number finish, a fold and the result load. The result sits in an
// output register, so the next expression's characters are accepted while it waits
// to be taken.
module infix_expression_evaluator #(
   parameter int FRAC_BITS           = 16,
   parameter int MAX_FRACTION_DIGITS = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_ch,
   input  logic                             req_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [47:0]               rsp_value,
   output logic                             rsp_valid_res,
   output logic                             rsp_arith_error
);

   // Tokens flowing from the classifier into the queue and out to the engine.
   ixe_pkg::token_type push_token;
   ixe_pkg::token_type head_token;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;

   // The classifier stalls the request side only when the queue is full.
   ixe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_token   (push_token)
   );

   ixe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .pop        (q_pop),
      .head_token (head_token),
      .full       (q_full),
      .empty      (q_empty)
   );

   // The engine drains tokens and owns the result register.
   ixe_back #(
      .FRAC_BITS           (FRAC_BITS),
      .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_token         (head_token),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_arith_error (rsp_arith_error)
   );

endmodule
